[design/quadratic_probe_hash_table_core_assert.svh]
// Assertion macros shared by the table core.
`ifndef QUADRATIC_PROBE_HASH_TABLE_CORE_ASSERT_SVH
`define QUADRATIC_PROBE_HASH_TABLE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define QPHT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define QPHT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define QPHT_ASSERT_IMP(lbl, ante, cons)
`define QPHT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[design/qpht_pkg.sv]
`timescale 1ns / 1ps
package qpht_pkg;

  localparam int SLOTS  = 64;
  localparam int SLOT_W = $clog2(SLOTS);

  typedef enum logic [1:0] {
    ST_EMPTY   = 2'd0,
    ST_LIVE    = 2'd1,
    ST_DELETED = 2'd2
  } slot_st_t;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_PROBE = 1'b1
  } fsm_t;

  typedef struct packed {
    logic [63:0] name_bytes;
    logic [15:0] room;
    logic [15:0] hostel;
    logic [31:0] id_number;
  } rec_t;

  typedef struct packed {
    logic              st_en;
    logic              rec_en;
    logic [SLOT_W-1:0] addr;
    slot_st_t          st;
    rec_t              rec;
  } wr_t;

endpackage

[design/qpht_store.sv]
`timescale 1ns / 1ps
module qpht_store
  import qpht_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SLOT_W-1:0] rd_addr,
  input  wr_t               wr,
  output slot_st_t          rd_st,
  output rec_t              rd_rec
);

  slot_st_t          st_mem [SLOTS];
  rec_t              rec_mem [SLOTS];
  logic [SLOTS-1:0]  valid_r;
  slot_st_t          st_q_r;
  rec_t              rec_q_r;
  logic              vld_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.st_en) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.st_en) begin
      st_mem[wr.addr] <= wr.st;
    end
    if (wr.rec_en) begin
      rec_mem[wr.addr] <= wr.rec;
    end
    st_q_r  <= st_mem[rd_addr];
    rec_q_r <= rec_mem[rd_addr];
    vld_q_r <= valid_r[rd_addr];
  end

  // untouched slot reads as empty
  assign rd_st  = vld_q_r ? st_q_r : ST_EMPTY;
  assign rd_rec = rec_q_r;

endmodule

[design/quadratic_probe_hash_table_core.sv]
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// input     start / busy           in_cmd, in_id_number, in_name_bytes, in_hostel, in_room
// result    out_strobe             out_ok
// config    cfg_we                 cfg_wdata (probe step)
//
// One probe per cycle through the slot-state memory read port; a beat ends at
// the slot it settles on or at the probe limit. out_strobe stands in the cycle after
// the last probe, when busy is already low and the next beat may be taken.
// Reset clears the per-slot valid bits at once; no clearing pass is needed.
// The receiver cannot stall: each result stands for exactly one cycle.
module quadratic_probe_hash_table_core
  import qpht_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_id_number,
  input  logic [63:0] in_name_bytes,
  input  logic [15:0] in_hostel,
  input  logic [15:0] in_room,
  output logic        out_strobe,
  output logic        out_ok,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

`include "quadratic_probe_hash_table_core_assert.svh"

  fsm_t              state_r, state_nxt;
  logic [15:0]       step_r;
  logic [1:0]        cmd_r;
  rec_t              key_r;
  logic [SLOT_W-1:0] home_r, off_r, off_nxt, delta_r, delta_nxt;
  logic [SLOT_W-1:0] cur_r, cnt_r, cnt_nxt;
  logic [SLOT_W-1:0] home_c, rd_addr;
  logic              strobe_r, strobe_nxt, ok_r, ok_nxt;
  logic              accept, match;
  wr_t               wr;
  slot_st_t          rd_st;
  rec_t              rd_rec;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  always_comb begin
    home_c = in_id_number[SLOT_W-1:0];
    for (int b = 0; b < 8; b++) begin
      home_c = home_c + SLOT_W'(in_name_bytes[8*b +: 8]);
    end
  end

  assign off_nxt   = off_r + delta_r;
  assign delta_nxt = delta_r + SLOT_W'({step_r, 1'b0});
  assign cnt_nxt   = cnt_r + SLOT_W'(1);
  assign rd_addr   = (state_r == S_IDLE) ? home_c : (home_r + off_nxt);
  assign match     = (rd_st == ST_LIVE) && (rd_rec == key_r);

  qpht_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_addr(rd_addr),
    .wr     (wr),
    .rd_st  (rd_st),
    .rd_rec (rd_rec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      step_r   <= 16'd1;
      strobe_r <= 1'b0;
      ok_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
      ok_r     <= ok_nxt;
      if (cfg_we) begin
        step_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_cmd;
      key_r   <= '{name_bytes: in_name_bytes, room: in_room, hostel: in_hostel,
                   id_number: in_id_number};
      home_r  <= home_c;
      off_r   <= '0;
      delta_r <= step_r[SLOT_W-1:0];
      cur_r   <= home_c;
      cnt_r   <= '0;
    end else if (state_r == S_PROBE) begin
      off_r   <= off_nxt;
      delta_r <= delta_nxt;
      cur_r   <= rd_addr;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    logic last;
    last       = (cnt_r == SLOT_W'(SLOTS - 1));
    state_nxt  = state_r;
    strobe_nxt = 1'b0;
    ok_nxt     = 1'b0;
    wr         = '{st_en: 1'b0, rec_en: 1'b0, addr: cur_r, st: ST_LIVE, rec: key_r};
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        case (cmd_t'(cmd_r))
          CMD_INSERT: begin
            if (rd_st != ST_LIVE) begin
              wr.st_en  = 1'b1;
              wr.rec_en = 1'b1;
              ok_nxt    = 1'b1;
              state_nxt = S_IDLE;
            end else if (last) begin
              state_nxt = S_IDLE;
            end
          end
          CMD_DELETE, CMD_SEARCH: begin
            if (rd_st == ST_EMPTY) begin
              state_nxt = S_IDLE;
            end else if (match) begin
              // tombstone on delete
              wr.st_en  = (cmd_t'(cmd_r) == CMD_DELETE);
              wr.st     = ST_DELETED;
              ok_nxt    = 1'b1;
              state_nxt = S_IDLE;
            end else if (last) begin
              state_nxt = S_IDLE;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
        strobe_nxt = (state_nxt == S_IDLE);
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_strobe = strobe_r;
  assign out_ok     = ok_r;

  `QPHT_ASSERT_IMP(a_strobe_idle, out_strobe, state_r == S_IDLE)
  `QPHT_ASSERT_IMP(a_ok_strobe, out_ok, out_strobe)
  `QPHT_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !out_strobe)
  `QPHT_ASSERT_IMP(a_wr_probe, wr.st_en, state_r == S_PROBE)
  `QPHT_ASSERT_NEXT(a_probe_bound, (state_r == S_PROBE) && (cnt_r == SLOT_W'(SLOTS - 1)),
                    state_r == S_IDLE && out_strobe)

endmodule
